// ----- rtl/core/csm_pkg.sv -----
// ---------------------------------------------------------------------------
// csm_pkg: shared constants of the compare-split merge block
// Key width, length register format and the default block depth.
// ---------------------------------------------------------------------------
package csm_pkg;

   // default number of elements per block (storage depth)
   localparam int CSM_BLOCK_DEPTH = 32;

   // sortable signed key
   localparam int KEY_W = 32;

   // block length register
   localparam int                LEN_W     = 6;
   localparam logic [LEN_W-1:0]  LEN_RESET = 6'd32;

endpackage

// ----- rtl/core/compare_split_merge.sv -----
// ---------------------------------------------------------------------------
// compare_split_merge: compare-split step of a parallel sort
// Each input transfer brings one element of the local and one of the
// partner's sorted block. Once a block is complete the two blocks are merged
// and the smallest or largest block_length elements are streamed out.
// ---------------------------------------------------------------------------
// A block of N elements (N = block_length, 0 taken as 1, capped at
// BLOCK_DEPTH) is loaded at one input transfer per cycle. The transfer that
// completes the block starts a merge: the PRIME_A and PRIME_B states prime
// the heads of the own and partner memories, then the merge keeps one element
// per cycle, set by the single read port of each memory. During the merge
// no input is taken. The kept block is then streamed at up to one result
// per cycle while the next block loads; the transfer that would complete
// the next block waits until all entries of the previous one have been
// read out.
module compare_split_merge #(
   parameter  int BLOCK_DEPTH = csm_pkg::CSM_BLOCK_DEPTH,
   localparam int CW = $clog2(BLOCK_DEPTH + 1),
   localparam int IW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration: block_length
   input  logic                        csr_wr_en,
   input  logic [csm_pkg::LEN_W-1:0]   csr_wr_data,
   // input channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [2*csm_pkg::KEY_W-1:0] req_tdata,  // own_value, partner_value
   input  logic                        req_tuser,  // keep_small
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [csm_pkg::KEY_W-1:0]   rsp_tdata,  // result_value
   output logic                        rsp_tlast,  // last_flag
   output logic                        rsp_tuser   // changed_flag
);
   import csm_pkg::*;

   localparam logic [LEN_W:0] DEPTH_EXT = (LEN_W + 1)'(BLOCK_DEPTH);

   logic [LEN_W-1:0] block_length_ff, block_length_in;
   logic [LEN_W:0]   bl_ext;
   logic [LEN_W:0]   len_wide;
   logic [CW-1:0]    len;

   logic             emit_busy;
   logic             kept_we;
   logic [IW-1:0]    kept_addr;
   logic [KEY_W-1:0] kept_data;
   logic             done;
   logic [CW-1:0]    done_len;
   logic             done_changed;

   // length register
   assign block_length_in = csr_wr_en ? csr_wr_data : block_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= LEN_RESET;
      end else begin
         block_length_ff <= block_length_in;
      end
   end

   // effective length: zero acts as one, clamp to the storage depth
   assign bl_ext = {1'b0, block_length_ff};

   always_comb begin
      if (bl_ext == '0) begin
         len_wide = (LEN_W + 1)'(1);
      end else if (bl_ext > DEPTH_EXT) begin
         len_wide = DEPTH_EXT;
      end else begin
         len_wide = bl_ext;
      end
   end

   assign len = len_wide[CW-1:0];

   csm_merge #(
      .BLOCK_DEPTH(BLOCK_DEPTH)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .len           (len),
      .req_valid     (req_tvalid),
      .req_own       (req_tdata[KEY_W-1:0]),
      .req_partner   (req_tdata[2*KEY_W-1:KEY_W]),
      .req_keep_small(req_tuser),
      .emit_busy     (emit_busy),
      .req_ready     (req_tready),
      .kept_we       (kept_we),
      .kept_addr     (kept_addr),
      .kept_data     (kept_data),
      .done          (done),
      .done_len      (done_len),
      .done_changed  (done_changed)
   );

   csm_emit #(
      .BLOCK_DEPTH(BLOCK_DEPTH)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .kept_we      (kept_we),
      .kept_addr    (kept_addr),
      .kept_data    (kept_data),
      .start        (done),
      .start_len    (done_len),
      .start_changed(done_changed),
      .busy         (emit_busy),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ----- rtl/core/csm_merge.sv -----
// ---------------------------------------------------------------------------
// csm_merge: block loader and merge engine
// Loads the own and partner blocks into two synchronous memories, then
// merges them one kept element per cycle, from the front or from the back.
// Each memory port prefetches the entry after its current head, so a head
// can be replaced in the same cycle it is consumed.
// ---------------------------------------------------------------------------
module csm_merge #(
   parameter  int BLOCK_DEPTH = csm_pkg::CSM_BLOCK_DEPTH,
   localparam int IW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1,
   localparam int CW = $clog2(BLOCK_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [CW-1:0]                     len,
   input  logic                              req_valid,
   input  logic signed [csm_pkg::KEY_W-1:0]  req_own,
   input  logic signed [csm_pkg::KEY_W-1:0]  req_partner,
   input  logic                              req_keep_small,
   input  logic                              emit_busy,
   output logic                              req_ready,
   output logic                              kept_we,
   output logic [IW-1:0]                     kept_addr,
   output logic [csm_pkg::KEY_W-1:0]         kept_data,
   output logic                              done,
   output logic [CW-1:0]                     done_len,
   output logic                              done_changed
);
   import csm_pkg::*;

   localparam logic [1:0] ST_LOAD    = 2'd0;
   localparam logic [1:0] ST_PRIME_A = 2'd1;
   localparam logic [1:0] ST_PRIME_B = 2'd2;
   localparam logic [1:0] ST_MERGE   = 2'd3;

   logic [KEY_W-1:0] own_mem [BLOCK_DEPTH];
   logic [KEY_W-1:0] par_mem [BLOCK_DEPTH];

   logic [1:0]               state_ff, state_in;
   logic [IW-1:0]            load_cnt_ff, load_cnt_in;
   logic                     keep_ff, keep_in;
   logic                     changed_ff, changed_in;
   logic [CW-1:0]            len_ff, len_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            own_rem_ff, own_rem_in;
   logic [CW-1:0]            par_rem_ff, par_rem_in;
   logic [IW-1:0]            own_p_ff, own_p_in;
   logic [IW-1:0]            par_p_ff, par_p_in;
   logic [IW-1:0]            k_ff, k_in;
   logic signed [KEY_W-1:0]  own_head_ff, own_head_in;
   logic signed [KEY_W-1:0]  par_head_ff, par_head_in;
   logic signed [KEY_W-1:0]  own_rd_ff;
   logic signed [KEY_W-1:0]  par_rd_ff;

   logic [CW-1:0] cnt_plus;
   logic [CW-1:0] len_m1;
   logic          completing;
   logic          accept;
   logic [IW-1:0] start_ptr;
   logic [IW-1:0] step;
   logic          take_own;
   logic [IW-1:0] own_raddr;
   logic [IW-1:0] par_raddr;

   // block completes on the item that brings the fill up to the length
   assign cnt_plus   = CW'(load_cnt_ff) + CW'(1);
   assign completing = (cnt_plus >= len);
   assign req_ready  = (state_ff == ST_LOAD) && !(completing && emit_busy);
   assign accept     = req_valid && req_ready;

   // first head: index 0 from the front, length - 1 from the back
   assign len_m1    = len - CW'(1);
   assign start_ptr = req_keep_small ? '0 : len_m1[IW-1:0];
   assign step      = keep_ff ? IW'(1) : {IW{1'b1}};

   // pick the head to keep; ties go to the own element
   always_comb begin
      if (par_rem_ff == '0) begin
         take_own = 1'b1;
      end else if (own_rem_ff == '0) begin
         take_own = 1'b0;
      end else if (keep_ff) begin
         take_own = (own_head_ff <= par_head_ff);
      end else begin
         take_own = (par_head_ff <= own_head_ff);
      end
   end

   // read addresses: prime the heads, then prefetch the entry after each head
   always_comb begin
      case (state_ff)
         ST_PRIME_A: begin
            own_raddr = own_p_ff;
            par_raddr = par_p_ff;
         end
         ST_PRIME_B: begin
            own_raddr = own_p_ff + step;
            par_raddr = par_p_ff + step;
         end
         ST_MERGE: begin
            own_raddr = take_own ? own_p_ff + step + step : own_p_ff + step;
            par_raddr = take_own ? par_p_ff + step : par_p_ff + step + step;
         end
         default: begin
            own_raddr = own_p_ff;
            par_raddr = par_p_ff;
         end
      endcase
   end

   // kept element write and hand-off to the emitter
   assign kept_we      = (state_ff == ST_MERGE);
   assign kept_addr    = k_ff;
   assign kept_data    = take_own ? own_head_ff : par_head_ff;
   assign done         = (state_ff == ST_MERGE) && (cnt_ff == CW'(1));
   assign done_len     = len_ff;
   assign done_changed = changed_ff || !take_own;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      keep_in     = keep_ff;
      changed_in  = changed_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      own_rem_in  = own_rem_ff;
      par_rem_in  = par_rem_ff;
      own_p_in    = own_p_ff;
      par_p_in    = par_p_ff;
      k_in        = k_ff;
      own_head_in = own_head_ff;
      par_head_in = par_head_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && completing) begin
               state_in    = ST_PRIME_A;
               load_cnt_in = '0;
               keep_in     = req_keep_small;
               changed_in  = 1'b0;
               len_in      = len;
               cnt_in      = len;
               own_rem_in  = len;
               par_rem_in  = len;
               own_p_in    = start_ptr;
               par_p_in    = start_ptr;
               k_in        = start_ptr;
            end else if (accept) begin
               load_cnt_in = load_cnt_ff + IW'(1);
            end
         end
         ST_PRIME_A: begin
            state_in = ST_PRIME_B;
         end
         ST_PRIME_B: begin
            own_head_in = own_rd_ff;
            par_head_in = par_rd_ff;
            state_in    = ST_MERGE;
         end
         ST_MERGE: begin
            if (take_own) begin
               own_head_in = own_rd_ff;
               own_p_in    = own_p_ff + step;
               own_rem_in  = own_rem_ff - CW'(1);
            end else begin
               par_head_in = par_rd_ff;
               par_p_in    = par_p_ff + step;
               par_rem_in  = par_rem_ff - CW'(1);
               changed_in  = 1'b1;
            end
            k_in   = k_ff + step;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         keep_ff     <= 1'b0;
         changed_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         keep_ff     <= keep_in;
         changed_ff  <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      own_rem_ff  <= own_rem_in;
      par_rem_ff  <= par_rem_in;
      own_p_ff    <= own_p_in;
      par_p_ff    <= par_p_in;
      k_ff        <= k_in;
      own_head_ff <= own_head_in;
      par_head_ff <= par_head_in;
   end

   // own block memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept) begin
         own_mem[load_cnt_ff] <= req_own;
      end
      own_rd_ff <= own_mem[own_raddr];
   end

   // partner block memory
   always_ff @(posedge clock) begin
      if (accept) begin
         par_mem[load_cnt_ff] <= req_partner;
      end
      par_rd_ff <= par_mem[par_raddr];
   end

endmodule

// ----- rtl/core/csm_emit.sv -----
// ---------------------------------------------------------------------------
// csm_emit: kept-element memory and result streamer
// Holds the merged block and streams it out in ascending index order at up
// to one result per cycle through a read register and an output register.
// ---------------------------------------------------------------------------
module csm_emit #(
   parameter  int BLOCK_DEPTH = csm_pkg::CSM_BLOCK_DEPTH,
   localparam int IW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1,
   localparam int CW = $clog2(BLOCK_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      kept_we,
   input  logic [IW-1:0]             kept_addr,
   input  logic [csm_pkg::KEY_W-1:0] kept_data,
   input  logic                      start,
   input  logic [CW-1:0]             start_len,
   input  logic                      start_changed,
   output logic                      busy,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic [csm_pkg::KEY_W-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);
   import csm_pkg::*;

   logic [KEY_W-1:0] kept_mem [BLOCK_DEPTH];

   logic [CW-1:0]    rem_ff, rem_in;
   logic [IW-1:0]    raddr_ff, raddr_in;
   logic             chg_ff, chg_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [KEY_W-1:0] rd_data_ff;
   logic             rd_last_ff;
   logic             rd_chg_ff;
   logic             out_vld_ff, out_vld_in;
   logic [KEY_W-1:0] out_data_ff;
   logic             out_last_ff;
   logic             out_chg_ff;

   logic out_free;
   logic move;
   logic issue;
   logic final_read;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign move       = rd_vld_ff && out_free;
   assign issue      = (rem_ff != '0) && (!rd_vld_ff || move);
   assign final_read = (rem_ff == CW'(1));
   assign busy       = (rem_ff != '0);

   // read sequencing
   always_comb begin
      rem_in    = rem_ff;
      raddr_in  = raddr_ff;
      chg_in    = chg_ff;
      rd_vld_in = rd_vld_ff;
      if (start) begin
         rem_in   = start_len;
         raddr_in = '0;
         chg_in   = start_changed;
      end else if (issue) begin
         rem_in   = rem_ff - CW'(1);
         raddr_in = raddr_ff + IW'(1);
      end
      if (issue) begin
         rd_vld_in = 1'b1;
      end else if (move) begin
         rd_vld_in = 1'b0;
      end
   end

   // output register: load on a move, drop after a transfer
   always_comb begin
      out_vld_in = out_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         rem_ff     <= rem_in;
         rd_vld_ff  <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      raddr_ff <= raddr_in;
      chg_ff   <= chg_in;
   end

   // kept memory: write from the merge, read one entry per issue
   always_ff @(posedge clock) begin
      if (kept_we) begin
         kept_mem[kept_addr] <= kept_data;
      end
      if (issue) begin
         rd_data_ff <= kept_mem[raddr_ff];
         rd_last_ff <= final_read;
         rd_chg_ff  <= final_read && chg_ff;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (move) begin
         out_data_ff <= rd_data_ff;
         out_last_ff <= rd_last_ff;
         out_chg_ff  <= rd_chg_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_chg_ff;

endmodule

// ----- rtl/core/csm_checker.sv -----
// ---------------------------------------------------------------------------
// csm_checker: port-level checks of the compare-split merge block
// Watches the result channel: held results, changed flag placement, block
// framing and the reset state.
// ---------------------------------------------------------------------------
module csm_checker #(
   parameter  int BLOCK_DEPTH = csm_pkg::CSM_BLOCK_DEPTH,
   localparam int CW = $clog2(BLOCK_DEPTH + 1)
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [csm_pkg::KEY_W-1:0] rsp_tdata,
   input logic                      rsp_tlast,
   input logic                      rsp_tuser
);
   import csm_pkg::*;

   logic [CW-1:0] res_cnt_ff, res_cnt_in;
   logic          rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // count result transfers since the last end of block
   always_comb begin
      res_cnt_in = res_cnt_ff;
      if (rsp_xfer) begin
         res_cnt_in = rsp_tlast ? '0 : res_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_cnt_ff <= '0;
      end else begin
         res_cnt_ff <= res_cnt_in;
      end
   end

   // a stalled result holds its value and flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // the changed flag only rides on the final result of a block
   a_chg_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tuser)
      else $error("changed flag set on a non-final result");

   // a block never runs past the storage depth
   a_block_framing: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && (res_cnt_ff == CW'(BLOCK_DEPTH - 1)) |-> rsp_tlast)
      else $error("block longer than the storage depth");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind compare_split_merge csm_checker #(
   .BLOCK_DEPTH(BLOCK_DEPTH)
) u_csm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .rsp_tuser (rsp_tuser)
);

// ----- verif/csm_merge_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csm_merge_checker: result predictor and comparator for compare_split_merge
// Follows the block length register and every input transfer, merges each
// completed block itself and compares every result transfer, field by
// field, with the oldest kept element still due.
// ---------------------------------------------------------------------------
module csm_merge_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [csm_pkg::LEN_W-1:0]     csr_wr_data,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [2*csm_pkg::KEY_W-1:0]   req_tdata,  // own_value, partner_value
   input  logic                          req_tuser,  // keep_small
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [csm_pkg::KEY_W-1:0]     rsp_tdata,  // result_value
   input  logic                          rsp_tlast,  // last_flag
   input  logic                          rsp_tuser,  // changed_flag
   output int                            mismatch_total,
   output int                            kept_pending
);
   import csm_pkg::*;

   typedef struct {
      logic signed [KEY_W-1:0] value;
      logic                    changed;
      logic                    last;
   } kept_elem_type;

   kept_elem_type           kept_due[$];
   logic signed [KEY_W-1:0] own_rows     [CSM_BLOCK_DEPTH];
   logic signed [KEY_W-1:0] partner_rows [CSM_BLOCK_DEPTH];
   int                      fill_count;
   logic [LEN_W-1:0]        length_reg;
   int                      errors = 0;

   assign mismatch_total = errors;

   // length 0 acts as 1, anything past the depth as the depth
   function automatic int effective_length(input logic [LEN_W-1:0] len);
      if (len == '0)
         return 1;
      if (len > CSM_BLOCK_DEPTH)
         return CSM_BLOCK_DEPTH;
      return int'(len);
   endfunction

   function automatic void note_mismatch(input string field, input logic [KEY_W-1:0] want,
                                         input logic [KEY_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field,
               $signed(want), $signed(got));
   endfunction

   // store one pair; on the closing transfer merge and queue the kept block
   task automatic absorb_pair(input logic signed [KEY_W-1:0] own_v,
                              input logic signed [KEY_W-1:0] partner_v,
                              input logic keep_small);
      logic signed [KEY_W-1:0] merged [CSM_BLOCK_DEPTH];
      kept_elem_type           elem;
      logic                    took_partner;
      int                      eff, slot, i, j, k;
      eff  = effective_length(length_reg);
      slot = fill_count % CSM_BLOCK_DEPTH;
      own_rows[slot]     = own_v;
      partner_rows[slot] = partner_v;
      fill_count = slot + 1;
      if (fill_count < eff)
         return;
      took_partner = 1'b0;
      if (keep_small) begin
         // walk from the front, own wins a tie
         i = 0;
         j = 0;
         for (k = 0; k < eff; k++) begin
            if (j >= eff || (i < eff && own_rows[i] <= partner_rows[j])) begin
               merged[k] = own_rows[i];
               i++;
            end else begin
               merged[k] = partner_rows[j];
               j++;
               took_partner = 1'b1;
            end
         end
      end else begin
         // walk from the back, own wins a tie
         i = eff;
         j = eff;
         for (k = eff; k > 0; k--) begin
            if (j == 0 || (i > 0 && partner_rows[j-1] <= own_rows[i-1])) begin
               merged[k-1] = own_rows[i-1];
               i--;
            end else begin
               merged[k-1] = partner_rows[j-1];
               j--;
               took_partner = 1'b1;
            end
         end
      end
      fill_count = 0;
      for (k = 0; k < eff; k++) begin
         elem.value   = merged[k];
         elem.last    = (k == eff - 1);
         elem.changed = elem.last ? took_partner : 1'b0;
         kept_due.push_back(elem);
      end
   endtask

   // sample both channels and the register port on the rising edge
   always @(posedge clock) begin
      kept_elem_type want;
      if (reset) begin
         fill_count = 0;
         length_reg = LEN_RESET;
         kept_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (kept_due.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing due, expected none, got %0d",
                        $time, $signed(rsp_tdata));
            end else begin
               want = kept_due.pop_front();
               if (rsp_tdata !== want.value)
                  note_mismatch("result_value", want.value, rsp_tdata);
               if (rsp_tuser !== want.changed)
                  note_mismatch("changed_flag", KEY_W'(want.changed), KEY_W'(rsp_tuser));
               if (rsp_tlast !== want.last)
                  note_mismatch("last_flag", KEY_W'(want.last), KEY_W'(rsp_tlast));
            end
         end
         if (csr_wr_en)
            length_reg = csr_wr_data;
         if (req_tvalid && req_tready)
            absorb_pair(req_tdata[KEY_W-1:0], req_tdata[2*KEY_W-1:KEY_W], req_tuser);
      end
      kept_pending = kept_due.size();
   end

endmodule

// ----- verif/tb_compare_split_merge.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_compare_split_merge: stimulus and verdict for compare_split_merge
// Drives directed edge cases and mostly sorted random blocks over many block
// lengths with random idling on both channels, a long result back-pressure
// stretch and an idle-free stretch; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_compare_split_merge;
   import csm_pkg::*;

   localparam int LIMIT_CYCLES  = 150000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 80;
   localparam int ITEM_TARGET   = 460;
   localparam int KEY_MIN       = 32'h8000_0000;
   localparam int KEY_MAX       = 32'h7fff_ffff;

   typedef enum int {KEYS_WIDE, KEYS_NARROW, KEYS_EDGE, KEYS_NOISE} key_style_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LEN_W-1:0]   csr_wr_data;
   logic               req_tvalid;
   logic               req_tready;
   logic [2*KEY_W-1:0] req_tdata;  // own_value, partner_value
   logic               req_tuser;  // keep_small
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [KEY_W-1:0]   rsp_tdata;  // result_value
   logic               rsp_tlast;  // last_flag
   logic               rsp_tuser;  // changed_flag

   int mismatch_total;
   int kept_pending;
   int sent_items = 0;
   int cycle_count = 0;
   bit calm = 1'b0;
   bit hold_req = 1'b0;

   compare_split_merge u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   csm_merge_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_total (mismatch_total),
      .kept_pending   (kept_pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_tready = calm ? 1'b1 : ($urandom_range(99) >= 27);
      end
   end

   // offer one pair and hold it until the transfer
   task automatic push_item(input int own_v, input int partner_v, input bit keep);
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {partner_v, own_v};
      req_tuser  = keep;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_items++;
   endtask

   // drain every due result, then let any merge in flight finish
   task automatic settle();
      req_tvalid = 1'b0;
      while (kept_pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      settle();
      csr_wr_en   = 1'b1;
      csr_wr_data = len;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic int block_items(input logic [LEN_W-1:0] len);
      if (len == '0)
         return 1;
      return (len > CSM_BLOCK_DEPTH) ? CSM_BLOCK_DEPTH : int'(len);
   endfunction

   function automatic int draw_key(input key_style_type style);
      case (style)
         KEYS_NARROW: return int'($urandom_range(8)) - 4;
         KEYS_EDGE: begin
            case ($urandom_range(4))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return 0;
               3: return -1;
               default: return int'($urandom);
            endcase
         end
         default: return int'($urandom);
      endcase
   endfunction

   // send count pairs; sorted unless noise, keep_small random before the last
   task automatic send_block(input int count, input bit keep, input key_style_type style);
      int own_q[$];
      int partner_q[$];
      int n;
      for (n = 0; n < count; n++) begin
         own_q.push_back(draw_key(style));
         partner_q.push_back(draw_key(style));
      end
      if (style != KEYS_NOISE) begin
         own_q.sort();
         partner_q.sort();
      end
      for (n = 0; n < count; n++)
         push_item(own_q[n], partner_q[n], (n == count - 1) ? keep : bit'($urandom_range(1)));
   endtask

   initial begin
      logic [LEN_W-1:0] len_code;
      int               eff, blocks, b, pick;
      key_style_type    style;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // single-element blocks at the key extremes, ties included
      write_length(6'd1);
      push_item(KEY_MIN, KEY_MAX, 1'b1);
      push_item(KEY_MAX, KEY_MIN, 1'b0);
      push_item(KEY_MIN, KEY_MIN, 1'b1);
      push_item(KEY_MAX, KEY_MAX, 1'b0);
      push_item(0, -1, 1'b1);

      // partner interleaves on keep-small; equal blocks on keep-large
      write_length(6'd4);
      push_item(10, -5, 1'b0);
      push_item(20, 15, 1'b0);
      push_item(30, 25, 1'b0);
      push_item(40, 35, 1'b1);
      push_item(1, 1, 1'b1);
      push_item(2, 2, 1'b1);
      push_item(3, 3, 1'b1);
      push_item(4, 4, 1'b0);

      // zero length acts as one
      write_length(6'd0);
      push_item(5, -7, 1'b0);
      push_item(-7, 5, 1'b1);

      // shrink the length part way through a block
      write_length(6'd8);
      push_item(-3, 7, 1'b0);
      push_item(2, 8, 1'b0);
      push_item(6, 9, 1'b0);
      write_length(6'd2);
      push_item(11, 12, 1'b1);

      // long result hold-off while full blocks keep coming
      write_length(6'd32);
      calm = 1'b1;
      hold_req = 1'b1;
      repeat (3) send_block(32, bit'($urandom_range(1)), KEYS_WIDE);
      write_length(6'd5);
      repeat (8) send_block(5, bit'($urandom_range(1)), KEYS_NARROW);
      calm = 1'b0;

      // random phases over the whole register range
      while (sent_items < ITEM_TARGET) begin
         pick = $urandom_range(9);
         case (pick)
            5:       len_code = 6'd32;
            6:       len_code = 6'd0;
            7:       len_code = LEN_W'($urandom_range(33, 63));
            8:       len_code = LEN_W'($urandom_range(9, 31));
            9:       len_code = 6'd63;
            default: len_code = LEN_W'($urandom_range(1, 8));
         endcase
         write_length(len_code);
         eff = block_items(len_code);
         blocks = $urandom_range(1, 24 / eff + 1);
         for (b = 0; b < blocks; b++) begin
            pick = $urandom_range(9);
            if (pick < 5)
               style = KEYS_WIDE;
            else if (pick < 7)
               style = KEYS_NARROW;
            else if (pick < 9)
               style = KEYS_EDGE;
            else
               style = KEYS_NOISE;
            send_block(eff, bit'($urandom_range(1)), style);
         end
         // leave a block half loaded for the next length to pick up
         if (eff > 1 && $urandom_range(3) == 0)
            send_block($urandom_range(1, eff - 1), bit'($urandom_range(1)), KEYS_WIDE);
      end

      settle();
      if (mismatch_total == 0 && kept_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
